/* rtl/cppf_pkg.sv */
// ----------------------------------------------------------------------------
// Column projection peak finder package
// Shared widths, register indexes, reset values and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cppf_pkg;

  // Payload widths.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PCOL_W  = 7;
  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 1'b1;
  localparam logic [CFG_DATA_W-1:0] THRESH_RST = 8'd20;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 8'd128;

  // Column geometry and result limits.
  localparam int unsigned MAX_WIDTH_DEF = 128;
  localparam int unsigned MIN_WIDTH     = 2;
  localparam int unsigned RESULT_LIMIT  = 63;
  localparam int unsigned RES_CNT_W     = $clog2(RESULT_LIMIT + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_take;   // a pixel transaction is accepted this cycle
    logic scan_load;  // arm the right-to-left column scan
    logic scan_step;  // read one column count and move left
    logic emit_load;  // arm the left-to-right peak pass
    logic emit_chk;   // consume the peak flag of the current column
    logic emit_adv;   // move to the next column
    logic fin_push;   // load the final result of the frame
  } cppf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_zero;  // scan address is at column zero
    logic peak_flag;  // peak flag of the current column
    logic pend_v;     // a peak waits to be sent
    logic slot_free;  // the output register can take a result
    logic emit_end;   // current column is the last peak candidate
    logic cnt_limit;  // one more peak reaches the result limit
    logic narrow;     // effective width has no peak candidates
  } cppf_sts_t;

endpackage

`default_nettype wire

/* rtl/column_projection_peak_finder_top.sv */
// ----------------------------------------------------------------------------
// Column projection peak finder
// Counts bright pixels per column over a frame and reports projection peaks.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on the input channel (in_valid_i,
// in_stall_o, pixel_i, frame_end_i), one transaction per cycle while no frame
// is being finished. A pixel above the threshold register adds one to its
// column count, which saturates. The transaction that carries frame_end_i
// closes the frame: the input then stalls while the count store is scanned
// from the right in the flush, scan and drain states (slope signs are formed
// and the counts are cleared), then while peak flags are read back from the
// left, a read and a check state per peak candidate column (columns 1 to
// width-2, the pass ends early at the 63rd peak), and while the final result
// is loaded. The pace of these passes is set by the single registered read
// port of each store. Each peak leaves as one output transaction (out_valid_o,
// out_stall_i, peak_column_o, peak_valid_o, last_o) in increasing column
// order, the last one flagged; a frame without peaks gives one transaction
// with peak_valid_o low. A stalled receiver holds the output register and
// pauses the peak pass, and the next frame may start while the final result
// still waits. After reset the block stalls its input while the count store
// is cleared. Configuration writes are taken at any time but belong to idle
// periods.
// ----------------------------------------------------------------------------
`default_nettype none

module column_projection_peak_finder_top import cppf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel channel.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  frame_end_i,
  // Result channel.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PCOL_W-1:0]          peak_column_o,
  output logic                       peak_valid_o,
  output logic                       last_o
);

  cppf_cmd_t cmd;
  cppf_sts_t sts;

  // The controller only sequences; all storage and arithmetic sit in the datapath.
  cppf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cppf_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_i       (pixel_i),
    .frame_end_i   (frame_end_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .peak_column_o (peak_column_o),
    .peak_valid_o  (peak_valid_o),
    .last_o        (last_o)
  );

  // A closing pixel must start the end-of-frame pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && frame_end_i) |=> in_stall_o)
    else $error("input not stalled after the closing pixel of a frame");

  // Ordinary pixels stream without a bubble.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !frame_end_i) |=> !in_stall_o)
    else $error("input stalled after an ordinary pixel");

  // The no-peak report is always the only and final result of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !peak_valid_o) |-> last_o)
    else $error("no-peak result without the last marker");

endmodule

`default_nettype wire

/* rtl/cppf_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cppf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cppf_ctrl.sv */
// ----------------------------------------------------------------------------
// Column projection peak finder controller
// Sequences pixel intake, the end-of-frame count scan and the peak pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cppf_ctrl import cppf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      frame_end_i,
  output logic           in_stall_o,
  input  wire cppf_sts_t sts_i,
  output cppf_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FLUSH    = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_DRAIN    = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_CHK = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       clr_q, clr_d;   // the scan after reset only clears the counts
  logic       hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SCAN;
      clr_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // A new peak cannot retire the pending one while the output is full.
  assign hold = sts_i.peak_flag && sts_i.pend_v && !sts_i.slot_free;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.pix_take = in_valid_i;
        if (in_valid_i && frame_end_i) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.scan_load = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_zero) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (clr_q) begin
          clr_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          cmd_o.emit_load = 1'b1;
          state_d         = sts_i.narrow ? S_FINISH : S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (!hold) begin
          cmd_o.emit_chk = 1'b1;
          if ((sts_i.peak_flag && sts_i.cnt_limit) || sts_i.emit_end) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.emit_adv = 1'b1;
            state_d        = S_EMIT_RD;
          end
        end
      end
      S_FINISH: begin
        if (sts_i.slot_free) begin
          cmd_o.fin_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* rtl/cppf_dpath.sv */
// ----------------------------------------------------------------------------
// Column projection peak finder datapath
// Configuration registers, column count store, slope scan and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module cppf_dpath import cppf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  frame_end_i,
  input  wire cppf_cmd_t             cmd_i,
  output cppf_sts_t                  sts_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [PCOL_W-1:0]          peak_column_o,
  output logic                       peak_valid_o,
  output logic                       last_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = AW + 1;
  localparam int unsigned CW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] thr_q;
  logic [CFG_DATA_W-1:0] wid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RST;
      wid_q <= WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_WIDTH:     wid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective width, clamped to the supported column range.
  logic [CW-1:0] wid_ext;
  logic [CW-1:0] wid_clamp;
  logic [WW-1:0] w_eff;

  always_comb begin
    wid_ext = CW'(wid_q);
    if (wid_ext < CW'(MIN_WIDTH)) begin
      wid_clamp = CW'(MIN_WIDTH);
    end else if (wid_ext > CW'(MAX_WIDTH)) begin
      wid_clamp = CW'(MAX_WIDTH);
    end else begin
      wid_clamp = wid_ext;
    end
  end

  assign w_eff = WW'(wid_clamp);

  // Column position of the incoming pixel.
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] col;
  logic [WW-1:0] col_nxt;

  assign col     = ({1'b0, pos_q} >= w_eff) ? '0 : pos_q;
  assign col_nxt = {1'b0, col} + WW'(1);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pix_take) begin
      if (frame_end_i || (col_nxt >= w_eff)) begin
        pos_d = '0;
      end else begin
        pos_d = col_nxt[AW-1:0];
      end
    end
  end

  // Count update stage: read at accept, write back in the cycle after.
  logic          inc_v_q;
  logic          inc_hit_q;
  logic [AW-1:0] inc_addr_q;

  // End-of-frame scan, right to left.
  logic [AW-1:0]      scan_addr_q;
  logic               dv_q;
  logic [AW-1:0]      da_q;
  logic [COUNT_W-1:0] prev_q;
  logic               sgn_q;       // filled sign of the column pair to the right, 1 is up

  // Peak pass and output.
  logic [AW-1:0]        e_q;
  logic                 pend_v_q;
  logic [AW-1:0]        pend_col_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic                 out_v_q;
  logic [PCOL_W-1:0]    out_col_q;
  logic                 out_pv_q;
  logic                 out_last_q;
  logic                 push_pend;
  logic [AW+PCOL_W-1:0] pend_col_ext;
  logic [PCOL_W-1:0]    pend_col_7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      inc_v_q     <= 1'b0;
      scan_addr_q <= AW'(MAX_WIDTH - 1);
      dv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      out_v_q     <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      inc_v_q <= cmd_i.pix_take;
      dv_q    <= cmd_i.scan_step;
      if (cmd_i.scan_load) begin
        scan_addr_q <= AW'(MAX_WIDTH - 1);
      end else if (cmd_i.scan_step) begin
        scan_addr_q <= scan_addr_q - AW'(1);
      end
      if (cmd_i.emit_load || cmd_i.fin_push) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.emit_chk && sts_o.peak_flag) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.emit_load) begin
        cnt_q <= '0;
      end else if (cmd_i.emit_chk && sts_o.peak_flag) begin
        cnt_q <= cnt_q + RES_CNT_W'(1);
      end
      if (push_pend || cmd_i.fin_push) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Column count store.
  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [AW-1:0]      cnt_raddr;
  logic [COUNT_W-1:0] cnt_rdata;

  assign cnt_we    = (inc_v_q && inc_hit_q && (cnt_rdata != COUNT_MAX)) || dv_q;
  assign cnt_waddr = dv_q ? da_q : inc_addr_q;
  assign cnt_wdata = dv_q ? '0 : (cnt_rdata + COUNT_W'(1));
  assign cnt_raddr = cmd_i.scan_step ? scan_addr_q : col;

  cppf_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Slope sign of the pair (da, da+1); a flat pair copies the sign to its right.
  logic in_rng;
  logic up;
  logic peak_we;
  logic peak_wdata;
  logic peak_rdata;

  assign in_rng     = ({1'b0, da_q} < (w_eff - WW'(1)));
  assign up         = (prev_q > cnt_rdata) || ((prev_q == cnt_rdata) && sgn_q);
  assign peak_we    = dv_q && in_rng;
  assign peak_wdata = up && !sgn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take) begin
      inc_hit_q  <= (pixel_i > thr_q);
      inc_addr_q <= col;
    end
    if (cmd_i.scan_step) begin
      da_q <= scan_addr_q;
    end
    if (dv_q) begin
      prev_q <= cnt_rdata;
    end
    if (cmd_i.scan_load) begin
      sgn_q <= 1'b1;
    end else if (peak_we) begin
      sgn_q <= up;
    end
    if (cmd_i.emit_load) begin
      e_q <= AW'(1);
    end else if (cmd_i.emit_adv) begin
      e_q <= e_q + AW'(1);
    end
    if (cmd_i.emit_chk && peak_rdata) begin
      pend_col_q <= e_q;
    end
    if (push_pend || cmd_i.fin_push) begin
      out_col_q  <= pend_v_q ? pend_col_7 : '0;
      out_pv_q   <= pend_v_q;
      out_last_q <= cmd_i.fin_push;
    end
  end

  // Peak flag store, indexed by column.
  cppf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (peak_we),
    .waddr_i (da_q + AW'(1)),
    .wdata_i (peak_wdata),
    .raddr_i (e_q),
    .rdata_o (peak_rdata)
  );

  // Result selection.
  assign push_pend    = cmd_i.emit_chk && peak_rdata && pend_v_q;
  assign pend_col_ext = {{PCOL_W{1'b0}}, pend_col_q};
  assign pend_col_7   = pend_col_ext[PCOL_W-1:0];

  assign sts_o.scan_zero = (scan_addr_q == '0);
  assign sts_o.peak_flag = peak_rdata;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.slot_free = !out_v_q || !out_stall_i;
  assign sts_o.emit_end  = ({1'b0, e_q} == (w_eff - WW'(MIN_WIDTH)));
  assign sts_o.cnt_limit = (cnt_q == RES_CNT_W'(RESULT_LIMIT - 1));
  assign sts_o.narrow    = (w_eff == WW'(MIN_WIDTH));

  assign out_valid_o   = out_v_q;
  assign peak_column_o = out_col_q;
  assign peak_valid_o  = out_pv_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
